### rtl/core/shrs_pkg.sv
package shrs_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_LATEST  = 3'd1,
    OP_HISTORY = 3'd2,
    OP_COUNT   = 3'd3,
    OP_RIDX    = 3'd4,
    OP_TOP     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_NONE   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DONE   = 2'd3
  } status_e;

  // Kind of pass over the stored records
  typedef enum logic [1:0] {
    P_CNT  = 2'd0,
    P_EMIT = 2'd1,
    P_SEL  = 2'd2
  } pass_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [KEY_W-1:0]   sensor_key;
    logic [3:0]         reading_type;
    logic signed [31:0] reading_value;
    logic [31:0]        reading_payload;
    logic [5:0]         logical_index;
    logic [CNT_W-1:0]   result_limit;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   rec_key;
    logic [3:0]         rec_type;
    logic signed [31:0] rec_value;
    logic [31:0]        rec_payload;
    logic [1:0]         status;
    logic [CNT_W-1:0]   match_count;
    logic [CNT_W-1:0]   stored_count;
    logic [31:0]        total_added;
    logic               last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    add;
    logic    pass_start;
    pass_e   pass;
    logic    issue;
    logic    ridx_issue;
    logic    out_simple;
    status_e out_status;
    logic    out_use_n;
    logic    out_rd;
    logic    out_best;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_zero;
    logic scan_last;
    logic idx_ok;
    logic nret_zero;
    logic sel_final;
  } dp_stat_t;

endpackage

### rtl/core/shrs_ctrl.sv
module shrs_ctrl
  import shrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic [2:0] op_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_CNT_SCAN, S_CNT_DRAIN, S_CNT_POST, S_EMIT_SCAN, S_EMIT_DRAIN,
    S_SEL_SCAN, S_SEL_DRAIN, S_SEL_POST, S_RIDX_WAIT
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] op_q;

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.pass       = P_CNT;
    cmd_o.out_status = ST_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (op_i)
            OP_ADD: begin
              cmd_o.add        = 1'b1;
              cmd_o.out_simple = 1'b1;
              cmd_o.out_status = ST_DONE;
            end
            OP_LATEST, OP_HISTORY, OP_COUNT, OP_TOP: begin
              if (stat_i.fill_zero) begin
                cmd_o.out_simple = 1'b1;
                cmd_o.out_status = (op_i == OP_COUNT) ? ST_DONE : ST_NONE;
              end else begin
                cmd_o.pass_start = 1'b1;
                cmd_o.pass       = P_CNT;
                state_d          = S_CNT_SCAN;
              end
            end
            OP_RIDX: begin
              if (stat_i.idx_ok) begin
                cmd_o.ridx_issue = 1'b1;
                state_d          = S_RIDX_WAIT;
              end else begin
                cmd_o.out_simple = 1'b1;
                cmd_o.out_status = ST_RANGE;
              end
            end
            default: begin
              cmd_o.out_simple = 1'b1;
              cmd_o.out_status = ST_NONE;
            end
          endcase
        end
      end
      S_CNT_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) state_d = S_CNT_DRAIN;
      end
      S_CNT_DRAIN: state_d = S_CNT_POST;
      S_CNT_POST: begin
        priority if (op_q == OP_COUNT) begin
          cmd_o.out_simple = 1'b1;
          cmd_o.out_status = ST_DONE;
          cmd_o.out_use_n  = 1'b1;
          state_d          = S_IDLE;
        end else if (stat_i.nret_zero) begin
          cmd_o.out_simple = 1'b1;
          cmd_o.out_status = ST_NONE;
          state_d          = S_IDLE;
        end else if (op_q == OP_TOP) begin
          cmd_o.pass_start = 1'b1;
          cmd_o.pass       = P_SEL;
          state_d          = S_SEL_SCAN;
        end else begin
          cmd_o.pass_start = 1'b1;
          cmd_o.pass       = P_EMIT;
          state_d          = S_EMIT_SCAN;
        end
      end
      S_EMIT_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) state_d = S_EMIT_DRAIN;
      end
      S_EMIT_DRAIN: state_d = S_IDLE;
      S_SEL_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) state_d = S_SEL_DRAIN;
      end
      S_SEL_DRAIN: state_d = S_SEL_POST;
      S_SEL_POST: begin
        cmd_o.out_best = 1'b1;
        if (stat_i.sel_final) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.pass_start = 1'b1;
          cmd_o.pass       = P_SEL;
          state_d          = S_SEL_SCAN;
        end
      end
      S_RIDX_WAIT: begin
        cmd_o.out_rd = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and captured op
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) op_q <= op_i;
    end
  end

endmodule

### rtl/core/shrs_datapath.sv
module shrs_datapath
  import shrs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  dp_cmd_t    ctl_i,
  output dp_stat_t   stat_o,
  output logic       result_valid_o,
  output result_t    result_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = 8;
  localparam logic [PW-1:0]    DEPTH_P = PW'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Record store
  logic [KEY_W-1:0]             mem_key [DEPTH];
  logic [3:0]                   mem_type[DEPTH];
  logic signed [VALUE_BITS-1:0] mem_val [DEPTH];
  logic [31:0]                  mem_pay [DEPTH];

  // Ring and query state
  logic [AW-1:0]    wp_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      total_q, total_d;
  logic [3:0]       ttc_q;
  logic [KEY_W-1:0] key_q;
  logic [2:0]       op_q;
  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] s_q, n_q, e_q;
  pass_e            pass_q;
  logic [DEPTH-1:0] done_q;

  // Read stage
  logic                         rv_q;
  logic [AW-1:0]                rp_q;
  logic [KEY_W-1:0]             rk_q;
  logic [3:0]                   rt_q;
  logic signed [VALUE_BITS-1:0] rvl_q;
  logic [31:0]                  rpl_q;

  // Best candidate of a selection pass
  logic                         bval_q;
  logic [AW-1:0]                bi_q;
  logic [KEY_W-1:0]             bk_q;
  logic [3:0]                   bt_q;
  logic signed [VALUE_BITS-1:0] bv_q;
  logic [31:0]                  bp_q;

  logic             out_valid_q;
  result_t          out_q;

  // Logical to physical address
  logic [PW-1:0]    base, lg, tsum;
  logic [AW-1:0]    addr;
  logic [CNT_W-1:0] cap, nret, limit_cap;
  logic             match_key, match_temp, better;

  always_comb begin
    base = PW'(wp_q) + DEPTH_P - PW'(fill_q);
    if (base >= DEPTH_P) base = base - DEPTH_P;
    priority if (ctl_i.ridx_issue) lg = PW'(cmd_i.logical_index);
    else if (pass_q == P_EMIT)     lg = PW'(fill_q) - 8'd1 - PW'(s_q);
    else                           lg = PW'(s_q);
    tsum = base + lg;
    if (tsum >= DEPTH_P) tsum = tsum - DEPTH_P;
    addr = tsum[AW-1:0];
  end

  assign fill_d  = (ctl_i.add && fill_q < DEPTH_C) ? fill_q + 7'd1 : fill_q;
  assign total_d = ctl_i.add ? total_q + 32'd1 : total_q;

  assign limit_cap  = (cmd_i.result_limit > DEPTH_C) ? DEPTH_C : cmd_i.result_limit;
  assign cap        = (op_q == OP_LATEST) ? 7'd1 : limit_q;
  assign nret       = (n_q < cap) ? n_q : cap;
  assign match_key  = (rk_q == key_q);
  assign match_temp = (rt_q == ttc_q) && !done_q[rp_q];
  assign better     = !bval_q || (rvl_q > bv_q);

  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.scan_last = (s_q == fill_q - 7'd1);
  assign stat_o.idx_ok    = (CNT_W'(cmd_i.logical_index) < fill_q);
  assign stat_o.nret_zero = (nret == '0);
  assign stat_o.sel_final = (e_q + 7'd1 == nret);

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.add) begin
      mem_key[wp_q]  <= cmd_i.sensor_key;
      mem_type[wp_q] <= cmd_i.reading_type;
      mem_val[wp_q]  <= cmd_i.reading_value[VALUE_BITS-1:0];
      mem_pay[wp_q]  <= cmd_i.reading_payload;
    end
    if (ctl_i.issue || ctl_i.ridx_issue) begin
      rk_q  <= mem_key[addr];
      rt_q  <= mem_type[addr];
      rvl_q <= mem_val[addr];
      rpl_q <= mem_pay[addr];
      rp_q  <= addr;
    end
  end

  // Captured query and best candidate
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q   <= cmd_i.sensor_key;
      op_q    <= cmd_i.op;
      limit_q <= limit_cap;
    end
    if (rv_q && pass_q == P_SEL && match_temp && better) begin
      bi_q <= rp_q;
      bk_q <= rk_q;
      bt_q <= rt_q;
      bv_q <= rvl_q;
      bp_q <= rpl_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      ttc_q       <= '0;
      s_q         <= '0;
      n_q         <= '0;
      e_q         <= '0;
      pass_q      <= P_CNT;
      done_q      <= '0;
      rv_q        <= 1'b0;
      bval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ttc_q <= cfg_wdata_i;
      fill_q  <= fill_d;
      total_q <= total_d;
      if (ctl_i.add) wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
      rv_q <= ctl_i.issue;
      if (ctl_i.load) begin
        n_q    <= '0;
        e_q    <= '0;
        done_q <= '0;
      end
      if (ctl_i.pass_start) begin
        s_q    <= '0;
        pass_q <= ctl_i.pass;
        bval_q <= 1'b0;
      end else if (ctl_i.issue) begin
        s_q <= s_q + 7'd1;
      end
      // Evaluate one read record
      if (rv_q && pass_q == P_CNT &&
          ((op_q == OP_TOP) ? (rt_q == ttc_q) : match_key)) n_q <= n_q + 7'd1;
      if (rv_q && pass_q == P_SEL && match_temp && better) bval_q <= 1'b1;
      if (rv_q && pass_q == P_EMIT && match_key && e_q < nret) e_q <= e_q + 7'd1;
      if (ctl_i.out_best) begin
        done_q[bi_q] <= 1'b1;
        e_q          <= e_q + 7'd1;
      end
      out_valid_q <= ctl_i.out_simple || ctl_i.out_rd || ctl_i.out_best ||
                     (rv_q && pass_q == P_EMIT && match_key && e_q < nret);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    out_q.stored_count <= fill_d;
    out_q.total_added  <= total_d;
    priority if (ctl_i.out_simple) begin
      out_q.rec_key     <= '0;
      out_q.rec_type    <= '0;
      out_q.rec_value   <= '0;
      out_q.rec_payload <= '0;
      out_q.status      <= ctl_i.out_status;
      out_q.match_count <= ctl_i.out_use_n ? n_q : '0;
      out_q.last        <= 1'b1;
    end else if (ctl_i.out_rd) begin
      out_q.rec_key     <= rk_q;
      out_q.rec_type    <= rt_q;
      out_q.rec_value   <= 32'(rvl_q);
      out_q.rec_payload <= rpl_q;
      out_q.status      <= ST_RECORD;
      out_q.match_count <= '0;
      out_q.last        <= 1'b1;
    end else if (ctl_i.out_best) begin
      out_q.rec_key     <= bk_q;
      out_q.rec_type    <= bt_q;
      out_q.rec_value   <= 32'(bv_q);
      out_q.rec_payload <= bp_q;
      out_q.status      <= ST_RECORD;
      out_q.match_count <= nret;
      out_q.last        <= (e_q + 7'd1 == nret);
    end else begin
      out_q.rec_key     <= rk_q;
      out_q.rec_type    <= rt_q;
      out_q.rec_value   <= 32'(rvl_q);
      out_q.rec_payload <= rpl_q;
      out_q.status      <= ST_RECORD;
      out_q.match_count <= nret;
      out_q.last        <= (e_q + 7'd1 == nret);
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

### rtl/core/sensor_history_ring_store_unit.sv
// Sensor history ring store.
// Command channel: cmd_i is taken when start is high and busy is low.
// Results: result_o is shown for one cycle with result_valid_o high; the
// receiver cannot stall, so every result must be taken as it appears.
// result_o.last marks the final result of a command.
// Configuration: cfg_we_i writes the temperature type code. The user must
// write it only when idle; the block itself does not enforce this.
// Add and unused ops: one result the cycle after the transfer, no busy time.
// Read index: the record is registered on read and again as the result.
// Latest, history: one counting pass over the stored records, then, if a
// record is to be returned, one output pass; one record read a cycle.
// Count: the counting pass alone, then one result with the match count.
// Top temperature: a counting pass, then one selection pass per returned
// record, each pass finding the largest remaining value.
// Reset clears the pointers and counters; record contents are not cleared.
module sensor_history_ring_store_unit
  import shrs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output logic       result_valid_o,
  output result_t    result_o
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  shrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (cmd_i.op),
    .stat_i (stat),
    .cmd_o  (ctl),
    .busy   (busy)
  );

  shrs_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef NO_ASSERTIONS
  // An add answers in the next cycle
  a_add_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.op == OP_ADD |=> result_valid_o && result_o.status == ST_DONE)
    else $error("add not answered");

  // Non-record results end their run
  a_nonrec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_RECORD |-> result_o.last)
    else $error("non-record result without last");

  // Fill never exceeds the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.stored_count <= CNT_W'(DEPTH))
    else $error("stored count above depth");
`endif

endmodule

### tb/tb_sensor_history_ring_store_unit.sv
`timescale 1ns / 1ps

module tb_sensor_history_ring_store_unit;
  import shrs_pkg::*;

  localparam int RING = 64;
  localparam int IDLE_LIMIT = 20000;
  // op codes with no function in the block
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef enum bit {K_CMD, K_CFG} stim_kind_e;
  typedef struct {
    stim_kind_e kind;
    logic [3:0] cfg_val;
    bit         no_idle;
    cmd_t       cmd;
  } stim_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd_i = '0;
  logic    cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic    result_valid_o;
  result_t result_o;

  sensor_history_ring_store_unit dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i,
    .cfg_we_i, .cfg_wdata_i, .result_valid_o, .result_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the ring and its counters
  logic [63:0] ring_key [RING];
  logic [3:0]  ring_type [RING];
  logic [31:0] ring_value [RING];
  logic [31:0] ring_payload [RING];
  int          wr_ptr = 0;
  int          fill = 0;
  logic [31:0] adds_seen = '0;
  logic [3:0]  temp_code = '0;

  stim_t   pending_q[$];
  result_t expected_q[$];
  int      errors = 0;
  bit      took = 1'b0;
  int      gap = 0;
  int      settle = 0;
  int      idle_cycles = 0;

  function automatic int slot(int logical);
    return (wr_ptr + RING - fill + logical) % RING;
  endfunction

  function automatic void queue_result(bit has_rec, int p, status_e st, int n);
    result_t r;
    r = '0;
    if (has_rec) begin
      r.rec_key = ring_key[p];
      r.rec_type = ring_type[p];
      r.rec_value = ring_value[p];
      r.rec_payload = ring_payload[p];
    end
    r.status = st;
    r.match_count = n[6:0];
    r.stored_count = fill[6:0];
    r.total_added = adds_seen;
    expected_q.push_back(r);
  endfunction

  // Work out the run of results for one accepted command
  function automatic void predict_records(cmd_t c);
    int sel[$];
    int lim, cap, p, j, cur;
    lim = (c.result_limit > RING) ? RING : int'(c.result_limit);
    case (c.op)
      OP_ADD: begin
        ring_key[wr_ptr] = c.sensor_key;
        ring_type[wr_ptr] = c.reading_type;
        ring_value[wr_ptr] = c.reading_value;
        ring_payload[wr_ptr] = c.reading_payload;
        wr_ptr = (wr_ptr + 1) % RING;
        if (fill < RING) fill++;
        adds_seen++;
        queue_result(1'b0, 0, ST_DONE, 0);
      end
      OP_LATEST, OP_HISTORY: begin
        cap = (c.op == OP_LATEST) ? 1 : lim;
        for (int i = 0; i < fill && sel.size() < cap; i++) begin
          p = slot(fill - 1 - i);
          if (ring_key[p] == c.sensor_key) sel.push_back(p);
        end
        if (sel.size() == 0) queue_result(1'b0, 0, ST_NONE, 0);
        foreach (sel[i]) queue_result(1'b1, sel[i], ST_RECORD, sel.size());
      end
      OP_COUNT: begin
        cap = 0;
        for (int i = 0; i < fill; i++)
          if (ring_key[slot(i)] == c.sensor_key) cap++;
        queue_result(1'b0, 0, ST_DONE, cap);
      end
      OP_RIDX: begin
        if (int'(c.logical_index) < fill)
          queue_result(1'b1, slot(c.logical_index), ST_RECORD, 0);
        else
          queue_result(1'b0, 0, ST_RANGE, 0);
      end
      OP_TOP: begin
        for (int i = 0; i < fill; i++)
          if (ring_type[slot(i)] == temp_code) sel.push_back(slot(i));
        // stable descending sort: equal values keep oldest first
        for (int i = 1; i < sel.size(); i++) begin
          cur = sel[i];
          j = i;
          while (j > 0 && $signed(ring_value[sel[j-1]]) < $signed(ring_value[cur])) begin
            sel[j] = sel[j-1];
            j--;
          end
          sel[j] = cur;
        end
        while (sel.size() > lim) void'(sel.pop_back());
        if (sel.size() == 0) queue_result(1'b0, 0, ST_NONE, 0);
        foreach (sel[i]) queue_result(1'b1, sel[i], ST_RECORD, sel.size());
      end
      default: queue_result(1'b0, 0, ST_NONE, 0);
    endcase
    expected_q[$].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: transfers, config writes and result checks at the rising edge
  always @(posedge clk_i) begin
    result_t e;
    took = rst_ni && start && !busy;
    if (took) predict_records(cmd_i);
    if (rst_ni && cfg_we_i) temp_code = cfg_wdata_i;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d key %0h", result_o.status, result_o.rec_key);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("rec_key", e.rec_key, result_o.rec_key);
        check_field("rec_type", e.rec_type, result_o.rec_type);
        check_field("rec_value", e.rec_value, result_o.rec_value);
        check_field("rec_payload", e.rec_payload, result_o.rec_payload);
        check_field("status", e.status, result_o.status);
        check_field("match_count", e.match_count, result_o.match_count);
        check_field("stored_count", e.stored_count, result_o.stored_count);
        check_field("total_added", e.total_added, result_o.total_added);
        check_field("last", e.last, result_o.last);
      end
    end
    if (took || result_valid_o || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: commands and config writes at the falling edge
  always @(negedge clk_i) begin
    logic nxt_start;
    logic nxt_we;
    nxt_start = start && !took;
    nxt_we = 1'b0;
    if (rst_ni && !nxt_start) begin
      if (gap > 0) begin
        gap--;
      end else if (pending_q.size() > 0) begin
        if (pending_q[0].kind == K_CFG) begin
          // only with the block idle and nothing outstanding
          if (expected_q.size() == 0 && !busy) begin
            if (settle >= 4) begin
              nxt_we = 1'b1;
              cfg_wdata_i <= pending_q[0].cfg_val;
              void'(pending_q.pop_front());
              settle = 0;
            end else begin
              settle++;
            end
          end else begin
            settle = 0;
          end
        end else begin
          cmd_i <= pending_q[0].cmd;
          gap = pending_q[0].no_idle ? 0 : $urandom_range(0, 8);
          void'(pending_q.pop_front());
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Stimulus
  task automatic add_cmd(logic [2:0] op, logic [63:0] key, logic [3:0] typ,
                         logic [31:0] val, logic [31:0] pay, logic [5:0] idx,
                         logic [6:0] lim, bit no_idle);
    stim_t s;
    s.kind = K_CMD;
    s.cfg_val = '0;
    s.no_idle = no_idle;
    s.cmd = '{op: op, sensor_key: key, reading_type: typ, reading_value: val,
              reading_payload: pay, logical_index: idx, result_limit: lim};
    pending_q.push_back(s);
  endtask

  task automatic add_cfg(logic [3:0] v);
    stim_t s;
    s.kind = K_CFG;
    s.cfg_val = v;
    s.no_idle = 1'b0;
    s.cmd = '0;
    pending_q.push_back(s);
  endtask

  logic [63:0] key_pool [6];
  logic [3:0]  phase_code [4];

  initial begin
    logic [2:0]  op;
    logic [63:0] key;
    logic [3:0]  typ;
    logic [31:0] val;
    logic [6:0]  lim;
    bit          burst;
    int          r;

    key_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7465_6d70_3100_0000,
                 64'h6875_6d00_0000_0000, 64'h1, 64'h8000_0000_0000_0000};
    phase_code[0] = 4'd3;
    phase_code[1] = 4'd15;
    phase_code[2] = 4'($urandom_range(1, 14));
    phase_code[3] = 4'd0;

    // Directed: empty store, unused ops, field extremes, ties, limits
    add_cfg(phase_code[0]);
    add_cmd(OP_LATEST, key_pool[0], 0, 0, 0, 0, 7'd1, 0);
    add_cmd(OP_HISTORY, key_pool[0], 0, 0, 0, 0, 7'd64, 0);
    add_cmd(OP_COUNT, key_pool[0], 0, 0, 0, 0, 0, 0);
    add_cmd(OP_RIDX, key_pool[0], 0, 0, 0, 6'd0, 0, 0);
    add_cmd(OP_TOP, key_pool[0], 0, 0, 0, 0, 7'd64, 0);
    add_cmd(OP_SPARE6, key_pool[1], 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 7'd64, 0);
    add_cmd(OP_SPARE7, key_pool[0], 0, 0, 0, 0, 0, 1);
    add_cmd(OP_ADD, key_pool[0], 4'd3, 32'h8000_0000, 32'h0, 0, 0, 1);
    add_cmd(OP_ADD, key_pool[1], 4'hF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1);
    add_cmd(OP_ADD, key_pool[2], 4'd3, 32'd5, 32'h1234_5678, 0, 0, 0);
    add_cmd(OP_ADD, key_pool[0], 4'd3, 32'd5, 32'hA5A5_A5A5, 0, 0, 0);
    add_cmd(OP_ADD, key_pool[2], 4'd3, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 0, 0, 0);
    add_cmd(OP_LATEST, key_pool[0], 0, 0, 0, 0, 0, 0);
    add_cmd(OP_HISTORY, key_pool[0], 0, 0, 0, 0, 7'd0, 0);
    add_cmd(OP_HISTORY, key_pool[2], 0, 0, 0, 0, 7'd64, 0);
    add_cmd(OP_COUNT, key_pool[0], 0, 0, 0, 0, 0, 0);
    add_cmd(OP_RIDX, key_pool[0], 0, 0, 0, 6'd4, 0, 0);
    add_cmd(OP_RIDX, key_pool[0], 0, 0, 0, 6'd5, 0, 0);
    add_cmd(OP_RIDX, key_pool[0], 0, 0, 0, 6'h3F, 0, 0);
    add_cmd(OP_TOP, key_pool[0], 0, 0, 0, 0, 7'd0, 0);
    add_cmd(OP_TOP, key_pool[0], 0, 0, 0, 0, 7'd64, 0);
    add_cmd(OP_TOP, key_pool[0], 0, 0, 0, 0, 7'd2, 0);

    // Random phases, each under its own temperature code
    for (int ph = 1; ph < 4; ph++) begin
      add_cfg(phase_code[ph]);
      burst = (ph == 2);
      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50) op = OP_ADD;
        else if (r < 97) op = 3'($urandom_range(1, 5));
        else op = r[0] ? OP_SPARE6 : OP_SPARE7;
        key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(0, 5)];
        typ = ($urandom_range(0, 9) < 4) ? phase_code[ph] : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
          0: val = 32'd5;
          1: val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        lim = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 64))
                                          : 7'($urandom_range(0, 8));
        add_cmd(op, key, typ, val, $urandom, 6'($urandom_range(0, 63)), lim,
                burst && (n < 30));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain, then let any stray result show up
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### sensor_history_ring_store_unit.f
rtl/core/shrs_pkg.sv
rtl/core/shrs_ctrl.sv
rtl/core/shrs_datapath.sv
rtl/core/sensor_history_ring_store_unit.sv
tb/tb_sensor_history_ring_store_unit.sv
